// ===== hw/rtl/ttfb_pkg.sv =====
// Shared types, constants and lookup functions for the tunnel texture feedback blend block.
`timescale 1ns / 1ps

package ttfb_pkg;

    localparam int INDEX_W = 14;
    localparam int BYTE_W  = 8;

    // Brightness floor subtracted from the halved plasma sum.
    localparam logic [6:0] TEXEL_FLOOR = 7'd64;
    // Saturated color.
    localparam logic [7:0] COLOR_MAX   = 8'd255;
    // Quarter period of the 256-step wave.
    localparam logic [6:0] QUARTER     = 7'd64;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [BYTE_W-1:0]  map_u;
        logic [BYTE_W-1:0]  map_v;
        logic               frame_last;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [BYTE_W-1:0]  out_color;
    } t_out_item;

    // Item entering the plasma pipe (coordinates already scrolled).
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  u;
        logic [BYTE_W-1:0]  v;
        logic [BYTE_W-1:0]  mv;
    } t_texel_req;

    // Item leaving the plasma pipe toward the frame store.
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  color;
    } t_blend_req;

    // Store status back to the top level.
    typedef struct packed {
        logic adv;       // whole pipe moves this cycle
        logic clearing;  // post-reset sweep in progress
    } t_store_stat;

    // 127*|sin| over a quarter wave, 65 points.
    localparam logic [6:0] QUARTER_WAVE [65] = '{
          7'd0,   7'd3,   7'd6,   7'd9,  7'd12,  7'd16,  7'd19,  7'd22,  7'd25,  7'd28,
         7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,  7'd49,  7'd51,  7'd54,  7'd57,
         7'd60,  7'd63,  7'd65,  7'd68,  7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,
         7'd85,  7'd88,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98, 7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
        7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
        7'd126, 7'd127, 7'd127, 7'd127, 7'd127
    };

    localparam logic [7:0] FADE_LUT [256] = '{
          8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,
          8'd6,   8'd7,   8'd8,   8'd9,  8'd10,  8'd11,  8'd12,  8'd12,
         8'd13,  8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd18,  8'd19,
         8'd20,  8'd21,  8'd22,  8'd23,  8'd23,  8'd24,  8'd25,  8'd26,
         8'd27,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,  8'd32,  8'd33,
         8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,
         8'd40,  8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,
         8'd47,  8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd52,
         8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd57,  8'd58,  8'd59,
         8'd60,  8'd61,  8'd62,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,
         8'd67,  8'd68,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,
         8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd78,  8'd79,
         8'd80,  8'd81,  8'd82,  8'd83,  8'd83,  8'd84,  8'd85,  8'd86,
         8'd87,  8'd88,  8'd88,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,
         8'd93,  8'd94,  8'd95,  8'd96,  8'd97,  8'd97,  8'd98,  8'd99,
        8'd100, 8'd101, 8'd102, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106,
        8'd107, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112, 8'd112,
        8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd117, 8'd118, 8'd119,
        8'd120, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126,
        8'd127, 8'd127, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133,
        8'd133, 8'd134, 8'd135, 8'd136, 8'd137, 8'd138, 8'd138, 8'd139,
        8'd140, 8'd141, 8'd142, 8'd143, 8'd143, 8'd144, 8'd145, 8'd146,
        8'd147, 8'd148, 8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153,
        8'd153, 8'd154, 8'd155, 8'd156, 8'd157, 8'd158, 8'd158, 8'd159,
        8'd160, 8'd161, 8'd162, 8'd163, 8'd163, 8'd164, 8'd165, 8'd166,
        8'd167, 8'd168, 8'd168, 8'd169, 8'd170, 8'd171, 8'd172, 8'd173,
        8'd173, 8'd174, 8'd175, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179,
        8'd180, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd186,
        8'd187, 8'd188, 8'd188, 8'd189, 8'd190, 8'd191, 8'd192, 8'd192,
        8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd197, 8'd198, 8'd199,
        8'd200, 8'd201, 8'd202, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206,
        8'd207, 8'd207, 8'd208, 8'd209, 8'd210, 8'd211, 8'd212, 8'd212
    };

    function automatic logic [7:0] abs_sin(input logic [7:0] i);
        logic [6:0] m;
        logic [6:0] k;
        m = i[6:0];
        k = (m <= QUARTER) ? m : 7'(8'd128 - {1'b0, m});
        return {1'b0, QUARTER_WAVE[k]};
    endfunction

    function automatic logic [7:0] abs_cos(input logic [7:0] i);
        logic [6:0] m;
        logic [6:0] k;
        m = i[6:0];
        k = (m <= QUARTER) ? (QUARTER - m) : (m - QUARTER);
        return {1'b0, QUARTER_WAVE[k]};
    endfunction

endpackage

// ===== hw/rtl/ttfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ttfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ttfb_texel.sv =====
// Four-stage plasma texel pipe: scrolled (v,u) in, brightened color out.
`timescale 1ns / 1ps

module ttfb_texel
    import ttfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_texel_req i_req,
    output t_blend_req o_req
);

    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [INDEX_W-1:0] idx;
        logic [7:0]         mv;
        logic [7:0]         v;
        logic [7:0]         rx;
        logic [7:0]         b;
    } t_s2;

    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [INDEX_W-1:0] idx;
        logic [7:0]         mv;
        logic [7:0]         rx;
        logic [7:0]         a;
        logic [7:0]         b;
    } t_s3;

    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [INDEX_W-1:0] idx;
        logic [7:0]         mv;
        logic [7:0]         a;
        logic [7:0]         b;
    } t_s4;

    t_texel_req r_s1;
    t_s2        r_s2, n_s2;
    t_s3        r_s3, n_s3;
    t_s4        r_s4;
    t_s4        n_s4;

    logic [15:0] w_t;
    logic [15:0] w_d;
    logic [7:0]  w_a2;
    logic [6:0]  w_half;
    logic [7:0]  w_tex;

    // stage 1: drift bytes from 5*t, first xor chain
    always_comb begin
        w_t           = {r_s1.v, r_s1.u};
        w_d           = w_t + {w_t[13:0], 2'b00};
        n_s2.valid    = r_s1.valid;
        n_s2.in_range = r_s1.in_range;
        n_s2.idx      = r_s1.idx;
        n_s2.mv       = r_s1.mv;
        n_s2.v        = r_s1.v;
        n_s2.rx       = w_d[7:0];
        n_s2.b        = (r_s1.u + abs_sin(r_s1.u)) ^ r_s1.v ^ w_d[15:8];
    end

    // stage 2: first cosine, add depth
    always_comb begin
        n_s3.valid    = r_s2.valid;
        n_s3.in_range = r_s2.in_range;
        n_s3.idx      = r_s2.idx;
        n_s3.mv       = r_s2.mv;
        n_s3.rx       = r_s2.rx;
        n_s3.a        = abs_cos(r_s2.b);
        n_s3.b        = r_s2.b + r_s2.v;
    end

    // stage 3: second cosine, xor low drift
    always_comb begin
        n_s4.valid    = r_s3.valid;
        n_s4.in_range = r_s3.in_range;
        n_s4.idx      = r_s3.idx;
        n_s4.mv       = r_s3.mv;
        n_s4.a        = r_s3.a;
        n_s4.b        = (r_s3.b + abs_cos(r_s3.b)) ^ r_s3.rx;
    end

    // stage 4: final sine, halve, floor, brighten by depth
    always_comb begin
        w_a2           = r_s4.a + abs_sin(r_s4.b);
        w_half         = w_a2[7:1];
        w_tex          = (w_half < TEXEL_FLOOR) ? 8'd0 : {1'b0, w_half - TEXEL_FLOOR};
        o_req.valid    = r_s4.valid;
        o_req.in_range = r_s4.in_range;
        o_req.idx      = r_s4.idx;
        o_req.color    = w_tex + r_s4.mv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else if (i_adv) begin
            r_s1 <= i_req;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

endmodule

// ===== hw/rtl/ttfb_store.sv =====
// Frame store read-modify-write: clear sweep, fade and saturating add, output register.
`timescale 1ns / 1ps

module ttfb_store
    import ttfb_pkg::*;
#(
    parameter int PIXELS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_blend_req  i_req,
    input  logic        i_out_stall,
    output t_store_stat o_stat,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    t_blend_req    r_d;
    logic          r_fwd;
    logic [7:0]    r_fwd_data;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          w_adv;
    logic [7:0]    w_rdata;
    logic [7:0]    w_old;
    logic [8:0]    w_sum;
    logic [7:0]    w_res;
    logic          w_we_item;
    logic          n_fwd;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;

    assign w_adv = !r_out_valid || !i_out_stall;

    // old value: zero when out of range, forwarded from the previous write to the same pixel, else RAM
    always_comb begin
        if (!r_d.in_range) begin
            w_old = 8'd0;
        end else if (r_fwd) begin
            w_old = r_fwd_data;
        end else begin
            w_old = w_rdata;
        end
        w_sum = {1'b0, FADE_LUT[w_old]} + {1'b0, r_d.color};
        w_res = w_sum[8] ? COLOR_MAX : w_sum[7:0];
    end

    always_comb begin
        w_we_item = w_adv && r_d.valid && r_d.in_range;
        n_fwd     = w_we_item && i_req.valid && (i_req.idx == r_d.idx);
        w_we      = r_clearing || w_we_item;
        w_waddr   = r_clearing ? r_clr_addr : AW'(r_d.idx);
        w_wdata   = r_clearing ? 8'd0 : w_res;
        w_re      = w_adv && i_req.valid && i_req.in_range;
    end

    ttfb_ram #(
        .WIDTH (8),
        .DEPTH (PIXELS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (AW'(i_req.idx)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d         <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_d         <= i_req;
            r_fwd       <= n_fwd;
            r_out_valid <= r_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fwd_data <= w_res;
            if (r_d.valid) begin
                r_out_data.out_index <= r_d.idx;
                r_out_data.out_color <= w_res;
            end
        end
    end

    assign o_stat.adv      = w_adv;
    assign o_stat.clearing = r_clearing;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

    a_clear_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_d.valid)
        else $error("pixel in blend stage during clear sweep");

    a_fwd_has_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_d.valid && r_d.in_range))
        else $error("forward flag without an in-range pixel in blend stage");

endmodule

// ===== hw/rtl/tunnel_texture_feedback_blend.sv =====
// Top level of the scrolling plasma tunnel with additive feedback trails.
`timescale 1ns / 1ps
// Path: an accepted transaction passes four plasma stages, one frame-store
//   read-modify-write stage and the output register; an output stall holds them all.
// Throughput: one pixel per cycle while not stalled; the single-port-write frame RAM
//   is read one stage ahead and a same-pixel hit on the write in flight is forwarded,
//   so no bubbles. Reset: scroll offset and pipe go empty; the frame store is then
//   swept to zero, with input stalled high, before the first transaction is taken.

module tunnel_texture_feedback_blend
    import ttfb_pkg::*;
#(
    parameter int PIXELS = 16384
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Pixel limit widened so that a 65536-entry store still compares correctly.
    localparam logic [16:0] PIX_LIM = 17'(PIXELS);

    logic        r_scroll;
    logic [7:0]  r_scroll_off;
    t_store_stat w_stat;
    logic        w_accept;
    t_texel_req  w_req;
    t_blend_req  w_blend;

    // The whole pipe moves on one enable: output register free or being taken.
    assign o_in_stall = !w_stat.adv || w_stat.clearing;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Scroll applies to u and v; unscrolled v rides along as brightness.
    always_comb begin
        w_req.valid    = w_accept;
        w_req.in_range = (17'(i_in_data.pixel_index) < PIX_LIM);
        w_req.idx      = i_in_data.pixel_index;
        w_req.u        = i_in_data.map_u + r_scroll_off;
        w_req.v        = i_in_data.map_v + r_scroll_off;
        w_req.mv       = i_in_data.map_v;
    end

    // Frame-last advances the offset for the next pixel, not this one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_off <= 8'd0;
        end else if (w_accept && i_in_data.frame_last) begin
            r_scroll_off <= r_scroll_off + 8'd1;
        end
    end

    // Registered flag: an accepted transaction carried frame-last (used by the check below).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll <= 1'b0;
        end else begin
            r_scroll <= w_accept && i_in_data.frame_last;
        end
    end

    ttfb_texel u_texel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_stat.adv),
        .i_req   (w_req),
        .o_req   (w_blend)
    );

    ttfb_store #(
        .PIXELS (PIXELS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_blend),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_scroll_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_scroll_off != $past(r_scroll_off))) |-> r_scroll)
        else $error("scroll offset moved without a frame-last transaction");

endmodule
